// File: hdl/dnle_pkg.sv
// Package for the DNS name label encoder.
// Holds the shared constants, the queue command and the result item types.
// Depends on nothing.
`default_nettype none

package dnle_pkg;

  // Largest label the block keeps, and the width of a label count
  localparam int LABEL_MAX_DEF = 62;
  localparam int CNT_W         = 6;

  // Label banks rotate between front and back
  localparam int NBANK  = 4;
  localparam int BANK_W = 2;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Character codes
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // Flush command handed from front to back
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  count;
    logic              ovf;
    logic              eon;
  } cmd_t;

  // One wire byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       is_length;
    logic       name_done;
    logic       truncated;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

// File: hdl/dns_name_label_encoder.sv
// DNS name label encoder: takes a dotted host name one character per item and
// emits DNS wire format. A plain character is accepted every cycle. A dot or
// end item queues a flush command (up to two wait; a dot after an empty label
// queues none); the back end then takes the command, emits the length byte,
// reads each stored character through the single memory read port and, for
// an end item, emits the zero byte, holding while the output buffer lacks room.
// Characters past LABEL_MAX are dropped and the label flagged.
// Uses dnle_pkg, dnle_fifo, dnle_label_ram, dnle_front and dnle_back.
`default_nettype none

module dns_name_label_encoder #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end_of_name,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_is_length,
  output logic            out_name_done,
  output logic            out_truncated,
  output logic            out_last_of_run
);

  import dnle_pkg::*;

  localparam int RAM_DEPTH = NBANK * LABEL_MAX;
  localparam int AW        = $clog2(RAM_DEPTH);
  localparam int CMD_W     = $bits(cmd_t);
  localparam int OUT_W     = $bits(out_t);
  localparam int CCW       = $clog2(CMD_DEPTH + 1);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  cmd_t           f_cmd, q_cmd;
  logic [CMD_W-1:0] q_cmd_vec;
  logic           cmd_push, cmd_pop, cmd_empty, cmd_full;
  logic [CCW-1:0] cmd_count;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data, rd_data;
  out_t           b_item, o_item;
  logic [OUT_W-1:0] o_item_vec;
  logic           out_push, out_empty, out_full;
  logic [OCW-1:0] out_count;

  dnle_front #(.LABEL_MAX(LABEL_MAX), .AW(AW)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_end_of_name (in_end_of_name),
    .cmd_push       (cmd_push),
    .cmd_data       (f_cmd),
    .cmd_full       (cmd_full),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  dnle_label_ram #(.DEPTH(RAM_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Flush command queue
  dnle_fifo #(.W(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (f_cmd),
    .pop       (cmd_pop),
    .pop_data  (q_cmd_vec),
    .empty     (cmd_empty),
    .full      (cmd_full),
    .count     (cmd_count)
  );

  assign q_cmd = cmd_t'(q_cmd_vec);

  dnle_back #(.LABEL_MAX(LABEL_MAX), .AW(AW), .OCW(OCW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_data  (q_cmd),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (b_item)
  );

  // Output buffer parts the back end from the result side
  dnle_fifo #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (b_item),
    .pop       (!out_stall),
    .pop_data  (o_item_vec),
    .empty     (out_empty),
    .full      (out_full),
    .count     (out_count)
  );

  assign o_item          = out_t'(o_item_vec);
  assign out_valid       = !out_empty;
  assign out_byte        = o_item.data;
  assign out_is_length   = o_item.is_length;
  assign out_name_done   = o_item.name_done;
  assign out_truncated   = o_item.truncated;
  assign out_last_of_run = o_item.last;

  // Back end never overruns the output buffer
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("output buffer overrun");

  // Front end never pushes into a full command queue
  a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (cmd_count != CCW'(CMD_DEPTH)))
    else $error("command queue overrun");

  // The zero byte closes the run and is no length byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_name_done) |-> (out_last_of_run && !out_is_length))
    else $error("name end without end of run");

  // A length byte is never zero
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_length) |-> (out_byte != 8'h00))
    else $error("zero label length");

endmodule

`default_nettype wire

// File: hdl/dnle_fifo.sv
// Small register FIFO used for the command queue and the output buffer.
// Generic width and depth; no package dependency.
`default_nettype none

module dnle_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  input  wire logic          pop,
  output logic [W-1:0]       pop_data,
  output logic               empty,
  output logic               full,
  output logic [CW-1:0]      count
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign count    = cnt_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dnle_label_ram.sv
// Label character memory: one write port, one registered read port.
// Generic depth; no package dependency.
`default_nettype none

module dnle_label_ram #(
  parameter int DEPTH = 248,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/dnle_front.sv
// Front end: accepts characters, stores them in the current bank, queues a
// flush command on an end item or a dot ending a non-empty label. Uses dnle_pkg.
`default_nettype none

module dnle_front #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
  parameter int AW        = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_ch,
  input  wire logic              in_end_of_name,
  output logic                   cmd_push,
  output dnle_pkg::cmd_t         cmd_data,
  input  wire logic              cmd_full,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [7:0]             wr_data
);

  import dnle_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic              is_flush;
  logic              accept;

  // Dot and end items flush; only they need room in the queue
  assign is_flush = in_end_of_name || (in_ch == DOT_CHAR);
  assign in_stall = is_flush && cmd_full;
  assign accept   = in_valid && !in_stall;

  assign wr_data  = in_ch;
  assign wr_addr  = AW'(AW'(bank_r) * AW'(LABEL_MAX) + AW'(count_r));

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    cmd_push  = 1'b0;
    wr_en     = 1'b0;
    cmd_data  = '{bank: bank_r, count: count_r, ovf: ovf_r, eon: in_end_of_name};
    if (accept) begin
      if (is_flush) begin
        // empty label with no end item has nothing to emit
        cmd_push  = (count_r != '0) || in_end_of_name;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        if (count_r != '0) begin
          bank_nxt = BANK_W'(bank_r + 1'b1);
        end
      end else if (count_r < CNT_W'(LABEL_MAX)) begin
        wr_en     = 1'b1;
        count_nxt = CNT_W'(count_r + 1'b1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dnle_back.sv
// Back end: takes flush commands and emits length, characters and, for an
// end item, the terminating zero into the output buffer. Uses dnle_pkg.
`default_nettype none

module dnle_back #(
  parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
  parameter int AW        = 8,
  parameter int OCW       = $clog2(dnle_pkg::OUT_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  dnle_pkg::cmd_t      cmd_data,
  output logic                cmd_pop,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  wire logic [7:0]     rd_data,
  input  wire logic [OCW-1:0] out_count,
  output logic                out_push,
  output dnle_pkg::out_t      out_item
);

  import dnle_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LEN, ST_CHARS, ST_ZERO} state_t;

  // Token held in a register while the memory read completes
  typedef struct packed {
    out_t item;
    logic is_char;
  } tok_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  tok_t             tok_r, tok_nxt;
  logic             tok_v_r, tok_v_nxt;
  logic [OCW:0]     used;
  logic             can_issue;
  logic             last_char;

  // Room check counts the token in flight
  assign used      = (OCW + 1)'(out_count) + (OCW + 1)'(tok_v_r);
  assign can_issue = used < (OCW + 1)'(OUT_DEPTH);
  assign last_char = (CNT_W'(idx_r + 1'b1) == cmd_r.count);
  assign rd_addr   = AW'(AW'(cmd_r.bank) * AW'(LABEL_MAX) + AW'(idx_r));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    tok_v_nxt = 1'b0;
    tok_nxt   = '{item: '{data: NUL_CHAR, is_length: 1'b0, name_done: 1'b0,
                          truncated: cmd_r.ovf, last: 1'b0},
                  is_char: 1'b0};
    cmd_pop   = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          idx_nxt = '0;
          if (cmd_data.count != '0) begin
            state_nxt = ST_LEN;
          end else if (cmd_data.eon) begin
            state_nxt = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        if (can_issue) begin
          tok_v_nxt              = 1'b1;
          tok_nxt.item.data      = 8'(cmd_r.count);
          tok_nxt.item.is_length = 1'b1;
          state_nxt              = ST_CHARS;
        end
      end
      ST_CHARS: begin
        if (can_issue) begin
          tok_v_nxt         = 1'b1;
          rd_en             = 1'b1;
          tok_nxt.is_char   = 1'b1;
          tok_nxt.item.last = last_char && !cmd_r.eon;
          idx_nxt           = CNT_W'(idx_r + 1'b1);
          if (last_char) begin
            state_nxt = cmd_r.eon ? ST_ZERO : ST_IDLE;
          end
        end
      end
      ST_ZERO: begin
        if (can_issue) begin
          tok_v_nxt              = 1'b1;
          tok_nxt.item.name_done = 1'b1;
          tok_nxt.item.truncated = 1'b0;
          tok_nxt.item.last      = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tok_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tok_v_r <= tok_v_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    tok_r <= tok_nxt;
  end

  // Merge memory data into character tokens
  always_comb begin
    out_push = tok_v_r;
    out_item = tok_r.item;
    if (tok_r.is_char) begin
      out_item.data = rd_data;
    end
  end

endmodule

`default_nettype wire
